/* rtl/sps_pkg.sv */
// ----------------------------------------------------------------------------
// Pairwise sum package
// Shared types and constants of the streaming pairwise binary64 summer.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int FP_W = 64;

    localparam logic [FP_W-1:0] FP_POS_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [FP_W-1:0] FP_DEF_NAN  = 64'hFFF8_0000_0000_0000;

    typedef logic [FP_W-1:0] t_fp;

    typedef struct packed {
        logic last;
        logic keep;
        logic ovf;
    } t_tag;

endpackage

/* rtl/sps_fpadd.sv */
// ----------------------------------------------------------------------------
// Binary64 adder
// Three-stage pipelined adder, round to nearest even, fixed latency.
// ----------------------------------------------------------------------------
module sps_fpadd (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sps_pkg::t_fp  i_a,
    input  sps_pkg::t_fp  i_b,
    output logic          o_valid,
    output sps_pkg::t_fp  o_sum
);
    import sps_pkg::*;

    function automatic logic [5:0] f_lzc(input logic [55:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd56;
        hit = 1'b0;
        for (int k = 55; k >= 0; k--) begin
            if (!hit && v[k]) begin
                n   = 6'(55 - k);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    // Stage 1: unpack, order by magnitude, align.
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    t_fp         x, y;
    logic [10:0] ex, ey, d;
    logic [52:0] mx, my;
    logic [55:0] yext, ysh;
    logic        ysticky;
    logic        spec;
    t_fp         specv;

    always_comb begin
        a_nan = (&i_a[62:52]) && (|i_a[51:0]);
        b_nan = (&i_b[62:52]) && (|i_b[51:0]);
        a_inf = (&i_a[62:52]) && !(|i_a[51:0]);
        b_inf = (&i_b[62:52]) && !(|i_b[51:0]);
        swap  = i_b[62:0] > i_a[62:0];
        x     = swap ? i_b : i_a;
        y     = swap ? i_a : i_b;
        ex    = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
        ey    = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
        mx    = {x[62:52] != 11'd0, x[51:0]};
        my    = {y[62:52] != 11'd0, y[51:0]};
        d     = ex - ey;
        yext  = {my, 3'b000};
        if (d >= 11'd56) begin
            ysh = {55'd0, |my};
        end else begin
            ysticky = |(yext & ~({56{1'b1}} << d[5:0]));
            ysh     = (yext >> d[5:0]) | {55'd0, ysticky};
        end
        ysticky = 1'b0;
        spec  = 1'b1;
        specv = FP_DEF_NAN;
        priority if (a_nan) begin
            specv = i_a | 64'h0008_0000_0000_0000;
        end else if (b_nan) begin
            specv = i_b | 64'h0008_0000_0000_0000;
        end else if (a_inf && b_inf && (i_a[63] != i_b[63])) begin
            specv = FP_DEF_NAN;
        end else if (a_inf) begin
            specv = i_a;
        end else if (b_inf) begin
            specv = i_b;
        end else begin
            spec = 1'b0;
        end
    end

    logic        r1_valid, r1_sx, r1_sub, r1_spec;
    logic [10:0] r1_ex;
    logic [55:0] r1_mx, r1_my;
    t_fp         r1_specv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_sx    <= x[63];
        r1_sub   <= x[63] ^ y[63];
        r1_spec  <= spec;
        r1_specv <= specv;
        r1_ex    <= ex;
        r1_mx    <= {mx, 3'b000};
        r1_my    <= ysh;
    end

    // Stage 2: add or subtract, count leading zeros.
    logic [56:0] sum;
    always_comb begin
        if (r1_sub) begin
            sum = {1'b0, r1_mx} - {1'b0, r1_my};
        end else begin
            sum = {1'b0, r1_mx} + {1'b0, r1_my};
        end
    end

    logic        r2_valid, r2_sx, r2_sub, r2_spec;
    logic [10:0] r2_ex;
    logic [56:0] r2_sum;
    logic [5:0]  r2_lz;
    t_fp         r2_specv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_sx    <= r1_sx;
        r2_sub   <= r1_sub;
        r2_spec  <= r1_spec;
        r2_specv <= r1_specv;
        r2_ex    <= r1_ex;
        r2_sum   <= sum;
        r2_lz    <= f_lzc(sum[55:0]);
    end

    // Stage 3: normalize, round, pack.
    logic [10:0] lim;
    logic [5:0]  sh;
    logic [55:0] m;
    logic [11:0] e, e2;
    logic        inc;
    logic [53:0] mr;
    logic [52:0] mant;
    t_fp         res;

    always_comb begin
        lim = r2_ex - 11'd1;
        sh  = ({5'd0, r2_lz} > lim) ? lim[5:0] : r2_lz;
        if (r2_sum[56]) begin
            m = {r2_sum[56:2], r2_sum[1] | r2_sum[0]};
            e = {1'b0, r2_ex} + 12'd1;
        end else begin
            m = r2_sum[55:0] << sh;
            e = {1'b0, r2_ex} - {6'd0, sh};
        end
        inc = m[2] & (m[1] | m[0] | m[3]);
        mr  = {1'b0, m[55:3]} + {53'd0, inc};
        if (mr[53]) begin
            mant = mr[53:1];
            e2   = e + 12'd1;
        end else begin
            mant = mr[52:0];
            e2   = e;
        end
        if (r2_spec) begin
            res = r2_specv;
        end else if (r2_sum == 57'd0) begin
            res = {r2_sub ? 1'b0 : r2_sx, 63'd0};
        end else if (e2 >= 12'd2047) begin
            res = {r2_sx, 11'h7FF, 52'd0};
        end else begin
            res = {r2_sx, mant[52] ? e2[10:0] : 11'd0, mant[51:0]};
        end
    end

    logic r3_valid;
    t_fp  r3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_sum <= res;
    end

    assign o_valid = r3_valid;
    assign o_sum   = r3_sum;

endmodule

/* rtl/sps_front.sv */
// ----------------------------------------------------------------------------
// Pairwise sum front end
// Counts items of a run, marks dropped items and queues them for the back end.
// ----------------------------------------------------------------------------
module sps_front #(
    parameter int LEVELS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  sps_pkg::t_fp       i_value,
    input  logic               i_last,
    output logic               o_q_valid,
    input  logic               i_q_pop,
    output sps_pkg::t_fp       o_q_value,
    output sps_pkg::t_tag      o_q_tag,
    output logic [LEVELS-1:0]  o_q_idx
);
    import sps_pkg::*;

    t_fp               r_val [2];
    t_tag              r_tag [2];
    logic [LEVELS-1:0] r_idx [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic [LEVELS-1:0] r_count;
    logic              r_drop;

    logic do_push, do_pop, keep;
    t_tag tag_in;

    assign full    = (r_cnt == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = i_q_pop && (r_cnt != 2'd0);
    assign keep    = (r_count != {LEVELS{1'b1}});

    always_comb begin
        tag_in.last = i_last;
        tag_in.keep = keep;
        tag_in.ovf  = r_drop || !keep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
                if (i_last) begin
                    r_count <= '0;
                    r_drop  <= 1'b0;
                end else if (keep) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
        if (do_push) begin
            r_val[r_wp] <= i_value;
            r_tag[r_wp] <= tag_in;
            r_idx[r_wp] <= r_count;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_value = r_val[r_rp];
    assign o_q_tag   = r_tag[r_rp];
    assign o_q_idx   = r_idx[r_rp];

endmodule

/* rtl/sps_back.sv */
// ----------------------------------------------------------------------------
// Pairwise sum back end
// Sequences the partial-sum stack through a shared adder and emits totals.
// ----------------------------------------------------------------------------
module sps_back #(
    parameter int LEVELS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  sps_pkg::t_fp       i_q_value,
    input  sps_pkg::t_tag      i_q_tag,
    input  logic [LEVELS-1:0]  i_q_idx,
    output logic               empty,
    input  logic               pop,
    output sps_pkg::t_fp       o_total,
    output logic               o_overflow
);
    import sps_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [LW:0] TOPL = (LW+1)'(LEVELS - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WAIT  = 6'b000010,
        S_COPY  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_SWAIT = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_fp               r_ps [LEVELS];
    t_tag              r_tag, n_tag;
    logic [LEVELS-1:0] r_idx, n_idx;
    logic [LEVELS-1:0] r_fin, n_fin;
    logic [LW-1:0]     r_lvl, n_lvl;
    t_fp               r_acc, n_acc;
    logic              r_ovalid, n_ovalid;
    t_fp               r_otot, n_otot;
    logic              r_oovf, n_oovf;

    logic          we;
    logic [LW-1:0] waddr;
    t_fp           wdata;
    logic [LW:0]   nxt;
    t_fp           rd;
    logic          add_go, add_valid;
    t_fp           add_a, add_b, add_sum;

    assign nxt = {1'b0, r_lvl} + 1'b1;
    assign rd  = (r_state == S_WAIT) ? r_ps[nxt[LW-1:0]] : r_ps[r_lvl];

    sps_fpadd u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (add_go),
        .i_a     (add_a),
        .i_b     (add_b),
        .o_valid (add_valid),
        .o_sum   (add_sum)
    );

    always_comb begin
        n_state  = r_state;
        n_tag    = r_tag;
        n_idx    = r_idx;
        n_fin    = r_fin;
        n_lvl    = r_lvl;
        n_acc    = r_acc;
        n_ovalid = r_ovalid && !pop;
        n_otot   = r_otot;
        n_oovf   = r_oovf;
        we       = 1'b0;
        waddr    = r_lvl;
        wdata    = add_sum;
        add_go   = 1'b0;
        add_a    = rd;
        add_b    = add_sum;
        o_q_pop  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_tag   = i_q_tag;
                    n_idx   = i_q_idx;
                    n_fin   = i_q_tag.keep ? i_q_idx + 1'b1 : i_q_idx;
                    n_lvl   = '0;
                    n_acc   = FP_POS_ZERO;
                    if (i_q_tag.keep && i_q_idx[0]) begin
                        add_go  = 1'b1;
                        add_a   = r_ps[0];
                        add_b   = i_q_value;
                        n_state = S_WAIT;
                    end else begin
                        if (i_q_tag.keep) begin
                            we    = 1'b1;
                            waddr = '0;
                            wdata = i_q_value;
                        end
                        n_state = i_q_tag.last ? S_SCAN : S_IDLE;
                    end
                end
            end
            S_WAIT: begin
                if (add_valid) begin
                    we    = 1'b1;
                    n_acc = add_sum;
                    n_lvl = nxt[LW-1:0];
                    if (nxt < TOPL && r_idx[nxt[LW-1:0]]) begin
                        add_go = 1'b1;
                        add_a  = rd;
                        add_b  = add_sum;
                    end else begin
                        n_state = S_COPY;
                    end
                end
            end
            S_COPY: begin
                we    = 1'b1;
                wdata = r_acc;
                n_lvl = '0;
                n_acc = FP_POS_ZERO;
                n_state = r_tag.last ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                if (r_fin[r_lvl]) begin
                    add_go  = 1'b1;
                    add_a   = r_acc;
                    add_b   = rd;
                    n_state = S_SWAIT;
                end else if ({1'b0, r_lvl} == TOPL) begin
                    n_state = S_EMIT;
                end else begin
                    n_lvl = nxt[LW-1:0];
                end
            end
            S_SWAIT: begin
                if (add_valid) begin
                    n_acc = add_sum;
                    if ({1'b0, r_lvl} == TOPL) begin
                        n_state = S_EMIT;
                    end else begin
                        n_lvl   = nxt[LW-1:0];
                        n_state = S_SCAN;
                    end
                end
            end
            S_EMIT: begin
                if (!n_ovalid) begin
                    n_ovalid = 1'b1;
                    n_otot   = r_acc;
                    n_oovf   = r_tag.ovf;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_lvl    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_lvl    <= n_lvl;
        end
        r_tag  <= n_tag;
        r_idx  <= n_idx;
        r_fin  <= n_fin;
        r_acc  <= n_acc;
        r_otot <= n_otot;
        r_oovf <= n_oovf;
        if (we) begin
            r_ps[waddr] <= wdata;
        end
    end

    assign empty      = !r_ovalid;
    assign o_total    = r_otot;
    assign o_overflow = r_oovf;

endmodule

/* rtl/streaming_pairwise_fp_sum.sv */
// ----------------------------------------------------------------------------
// Streaming pairwise binary64 summer
// Sums each run of binary64 values as a balanced binary tree and reports the
// total with a flag for dropped items.
// ----------------------------------------------------------------------------
// An item is transferred by push and full, a total by pop and empty. A run
// ends with the item whose last bit is set; only that item yields a total.
// A run holds up to 2^LEVELS-1 items, further items are dropped and set
// overflow. Every addition goes through one shared three-stage adder, and
// each dependent addition waits for the result of the one before it. A kept
// item at an even position in the run is written straight into the stack; an
// item at an odd position starts 1+t dependent additions, where t is the
// number of trailing ones of its position above bit zero. The final item
// adds a scan of the LEVELS stack levels, one more addition per set bit of
// the item count and a handover of the total. A two-entry queue in front lets
// new items be transferred while the stack works.
module streaming_pairwise_fp_sum #(
    parameter int LEVELS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  sps_pkg::t_fp  i_value,
    input  logic          i_last,
    output logic          empty,
    input  logic          pop,
    output sps_pkg::t_fp  o_total,
    output logic          o_overflow
);
    import sps_pkg::*;

    logic              q_valid, q_pop;
    t_fp               q_value;
    t_tag              q_tag;
    logic [LEVELS-1:0] q_idx;

    sps_front #(.LEVELS(LEVELS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_value   (i_value),
        .i_last    (i_last),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_value (q_value),
        .o_q_tag   (q_tag),
        .o_q_idx   (q_idx)
    );

    sps_back #(.LEVELS(LEVELS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q_value  (q_value),
        .i_q_tag    (q_tag),
        .i_q_idx    (q_idx),
        .empty      (empty),
        .pop        (pop),
        .o_total    (o_total),
        .o_overflow (o_overflow)
    );

endmodule
